// ----- hdl/risd_pkg.sv -----
// Package for the ray segment inverse distance core.
// Holds the widths shared by every module, the latency and the control struct.
package risd_pkg;

  // Coordinate width of every input field and fraction width of the result.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // A product of two coordinates, and a difference of two products.
  localparam int PROD_W  = 2 * COORD_BITS;
  localparam int CROSS_W = 2 * COORD_BITS + 1;

  // The denominator |dd| + |rn| reaches 2^(2*COORD_BITS), so it needs one bit more.
  localparam int DEN_W = 2 * COORD_BITS + 1;

  // The quotient holds 1.0 exactly, so it is one bit wider than the fraction.
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int DIV_STAGES = FRAC_BITS + 1;

  // Products, cross products, sign fold and hit test, divider, output register.
  localparam int LATENCY = 4 + DIV_STAGES + 1;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
  } risd_ctl_t;

endpackage

// ----- hdl/risd_cross.sv -----
// Two pipeline stages: six coordinate products, then the three cross products.
// Depends on risd_pkg for the widths.
module risd_cross import risd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic signed [COORD_BITS-1:0] offset_x_i,
  input  logic signed [COORD_BITS-1:0] offset_y_i,
  input  logic signed [COORD_BITS-1:0] segment_dx_i,
  input  logic signed [COORD_BITS-1:0] segment_dy_i,
  input  logic signed [COORD_BITS-1:0] ray_dx_i,
  input  logic signed [COORD_BITS-1:0] ray_dy_i,
  output logic                       valid_o,
  output logic signed [CROSS_W-1:0]  dd_o,
  output logic signed [CROSS_W-1:0]  sn_o,
  output logic signed [CROSS_W-1:0]  rn_o
);

  logic                      prod_valid_q;
  logic signed [PROD_W-1:0]  rx_sy_q, ry_sx_q, rx_oy_q, ry_ox_q, sx_oy_q, sy_ox_q;
  logic signed [PROD_W-1:0]  rx_sy_d, ry_sx_d, rx_oy_d, ry_ox_d, sx_oy_d, sy_ox_d;
  logic                      cross_valid_q;
  logic signed [CROSS_W-1:0] dd_q, sn_q, rn_q;
  logic signed [CROSS_W-1:0] dd_d, sn_d, rn_d;

  // First stage: the six products, each operand sign extended to full width.
  always_comb begin
    rx_sy_d = PROD_W'(ray_dx_i) * PROD_W'(segment_dy_i);
    ry_sx_d = PROD_W'(ray_dy_i) * PROD_W'(segment_dx_i);
    rx_oy_d = PROD_W'(ray_dx_i) * PROD_W'(offset_y_i);
    ry_ox_d = PROD_W'(ray_dy_i) * PROD_W'(offset_x_i);
    sx_oy_d = PROD_W'(segment_dx_i) * PROD_W'(offset_y_i);
    sy_ox_d = PROD_W'(segment_dy_i) * PROD_W'(offset_x_i);
  end

  // Second stage: the determinant and the two numerators.
  always_comb begin
    dd_d = CROSS_W'(rx_sy_q) - CROSS_W'(ry_sx_q);
    sn_d = CROSS_W'(rx_oy_q) - CROSS_W'(ry_ox_q);
    rn_d = CROSS_W'(sx_oy_q) - CROSS_W'(sy_ox_q);
  end

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q  <= 1'b0;
      cross_valid_q <= 1'b0;
    end else begin
      prod_valid_q  <= valid_i;
      cross_valid_q <= prod_valid_q;
    end
  end

  // Data registers of both stages.
  always_ff @(posedge clk_i) begin
    rx_sy_q <= rx_sy_d;
    ry_sx_q <= ry_sx_d;
    rx_oy_q <= rx_oy_d;
    ry_ox_q <= ry_ox_d;
    sx_oy_q <= sx_oy_d;
    sy_ox_q <= sy_ox_d;
    dd_q    <= dd_d;
    sn_q    <= sn_d;
    rn_q    <= rn_d;
  end

  assign valid_o = cross_valid_q;
  assign dd_o    = dd_q;
  assign sn_o    = sn_q;
  assign rn_o    = rn_q;

endmodule

// ----- hdl/risd_classify.sv -----
// Two pipeline stages: fold the sign of the determinant, then test for a hit
// and form the divider operands. Depends on risd_pkg.
module risd_classify import risd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [CROSS_W-1:0] dd_i,
  input  logic signed [CROSS_W-1:0] sn_i,
  input  logic signed [CROSS_W-1:0] rn_i,
  output risd_ctl_t                 ctl_o,
  output logic [DEN_W-1:0]          num_o,
  output logic [DEN_W-1:0]          den_o
);

  logic                      fold_valid_q;
  logic signed [CROSS_W-1:0] dd_q, sn_q, rn_q;
  logic signed [CROSS_W-1:0] dd_d, sn_d, rn_d;
  risd_ctl_t                 ctl_q, ctl_d;
  logic [DEN_W-1:0]          num_q, den_q, num_d, den_d;

  // Negate all three when the determinant is negative, so that dd >= 0.
  always_comb begin
    if (dd_i[CROSS_W-1]) begin
      dd_d = -dd_i;
      sn_d = -sn_i;
      rn_d = -rn_i;
    end else begin
      dd_d = dd_i;
      sn_d = sn_i;
      rn_d = rn_i;
    end
  end

  // Hit needs a nonzero determinant, 0 <= sn <= dd and rn >= 0.
  always_comb begin
    ctl_d.valid = fold_valid_q;
    ctl_d.hit   = (dd_q != '0) && !sn_q[CROSS_W-1] && (sn_q <= dd_q) && !rn_q[CROSS_W-1];
    num_d       = $unsigned(dd_q);
    den_d       = $unsigned(dd_q) + $unsigned(rn_q);
  end

  // Control registers of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_valid_q <= 1'b0;
      ctl_q        <= '0;
    end else begin
      fold_valid_q <= valid_i;
      ctl_q        <= ctl_d;
    end
  end

  // Data registers of both stages.
  always_ff @(posedge clk_i) begin
    dd_q  <= dd_d;
    sn_q  <= sn_d;
    rn_q  <= rn_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

// ----- hdl/risd_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, giving
// floor(num * 2^FRAC_BITS / den) for num <= den. Depends on risd_pkg.
module risd_divider import risd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  risd_ctl_t        ctl_i,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output risd_ctl_t        ctl_o,
  output logic [QUOT_W-1:0] quot_o
);

  risd_ctl_t         ctl_q  [DIV_STAGES];
  logic [DEN_W-1:0]  rem_q  [DIV_STAGES];
  logic [DEN_W-1:0]  den_q  [DIV_STAGES];
  logic [QUOT_W-1:0] quot_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [QUOT_W-1:0] quot_prev;
    logic [DEN_W-1:0]  den_in;
    risd_ctl_t         ctl_in;
    logic [DEN_W-1:0]  rem_d;
    logic [QUOT_W-1:0] quot_d;

    // Select the operands: the first stage takes the numerator unshifted.
    if (k == 0) begin : g_first
      always_comb begin
        trial     = {1'b0, num_i};
        quot_prev = '0;
        den_in    = den_i;
        ctl_in    = ctl_i;
      end
    end else begin : g_next
      always_comb begin
        trial     = {rem_q[k-1], 1'b0};
        quot_prev = quot_q[k-1];
        den_in    = den_q[k-1];
        ctl_in    = ctl_q[k-1];
      end
    end

    // Compare and subtract for one quotient bit.
    always_comb begin
      ge     = (trial >= {1'b0, den_in});
      rem_d  = DEN_W'(ge ? (trial - {1'b0, den_in}) : trial);
      quot_d = {quot_prev[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= rem_d;
      den_q[k]  <= den_in;
      quot_q[k] <= quot_d;
    end
  end

  assign ctl_o  = ctl_q[DIV_STAGES-1];
  assign quot_o = quot_q[DIV_STAGES-1];

`ifndef SYNTHESIS
  // A hit guarantees the numerator does not exceed the denominator.
  a_num_le_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid && ctl_i.hit |-> num_i <= den_i)
    else $error("divider operand: numerator above denominator on a hit");

  // The remainder is below the divisor at the last stage.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.valid && ctl_o.hit |-> rem_q[DIV_STAGES-1] < den_q[DIV_STAGES-1])
    else $error("divider remainder not below divisor");

  // A quotient of one has no fraction bits.
  a_quot_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.valid && ctl_o.hit && quot_o[QUOT_W-1] |-> quot_o[QUOT_W-2:0] == '0)
    else $error("divider quotient above one");
`endif

endmodule

// ----- hdl/ray_segment_inverse_distance_core.sv -----
// Top level of the ray segment inverse distance core.
// Depends on risd_pkg, risd_cross, risd_classify and risd_divider.
//
// Usage:
// A query is transferred at a rising clock edge where start is high and busy
// is low. busy never rises, so a new query may be issued in every cycle.
// Each query carries the segment-start-to-ray-origin offset, the segment
// direction and the ray direction, all signed coordinates.
// Exactly one result comes back per query, in order, on result_valid_o for a
// single cycle, with hit_o and inverse_distance_o. inverse_distance_o is
// 1/(r+1) in unsigned Q1.16 (65536 is 1.0) on a hit and zero otherwise.
// The pipeline holds two stages of products and cross products, two
// stages of sign fold and hit test, one divider stage per quotient bit
// (FRAC_BITS + 1) and one output register.
// Throughput is one query per cycle; the pipeline depth is set by the
// bit-per-stage divider. The receiver cannot stall, so nothing is held back.
// Reset clears all valid bits at once; no result appears until a query is
// transferred after reset.
module ray_segment_inverse_distance_core import risd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] offset_x_i,
  input  logic signed [COORD_BITS-1:0] offset_y_i,
  input  logic signed [COORD_BITS-1:0] segment_dx_i,
  input  logic signed [COORD_BITS-1:0] segment_dy_i,
  input  logic signed [COORD_BITS-1:0] ray_dx_i,
  input  logic signed [COORD_BITS-1:0] ray_dy_i,
  output logic                         result_valid_o,
  output logic [QUOT_W-1:0]            inverse_distance_o,
  output logic                         hit_o
);

  logic                      accept;
  logic                      cross_valid;
  logic signed [CROSS_W-1:0] dd, sn, rn;
  risd_ctl_t                 cls_ctl, div_ctl;
  logic [DEN_W-1:0]          num, den;
  logic [QUOT_W-1:0]         quot;
  logic                      valid_q, hit_q;
  logic [QUOT_W-1:0]         inv_q, inv_d;

  // The pipeline never stalls, so every start is a transfer.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  risd_cross u_cross (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .offset_x_i   (offset_x_i),
    .offset_y_i   (offset_y_i),
    .segment_dx_i (segment_dx_i),
    .segment_dy_i (segment_dy_i),
    .ray_dx_i     (ray_dx_i),
    .ray_dy_i     (ray_dy_i),
    .valid_o      (cross_valid),
    .dd_o         (dd),
    .sn_o         (sn),
    .rn_o         (rn)
  );

  risd_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cross_valid),
    .dd_i    (dd),
    .sn_i    (sn),
    .rn_i    (rn),
    .ctl_o   (cls_ctl),
    .num_o   (num),
    .den_o   (den)
  );

  risd_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cls_ctl),
    .num_i  (num),
    .den_i  (den),
    .ctl_o  (div_ctl),
    .quot_o (quot)
  );

  // Misses report zero inverse distance.
  assign inv_d = div_ctl.hit ? quot : '0;

  // Output register: strobe and hit flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= div_ctl.valid;
      hit_q   <= div_ctl.valid && div_ctl.hit;
    end
  end

  // Output register: result value.
  always_ff @(posedge clk_i) begin
    inv_q <= inv_d;
  end

  assign result_valid_o     = valid_q;
  assign hit_o              = hit_q;
  assign inverse_distance_o = inv_q;

`ifndef SYNTHESIS
  // Every result follows a query transfer by exactly the pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching query transfer");

  // A miss always reports zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |-> inverse_distance_o == '0)
    else $error("nonzero distance reported on a miss");

  // The hit flag is only raised with the strobe.
  a_hit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> result_valid_o)
    else $error("hit flag outside a result transfer");
`endif

endmodule

// ----- test/testbench.sv -----
// Testbench for the ray segment inverse distance core.
// Depends on risd_pkg and ray_segment_inverse_distance_core; it predicts each
// result with its own integer model of the hit test and checks every transfer.
module testbench;
  import risd_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One ray query as it is driven onto the ports.
  typedef struct packed {
    coord_t offset_x;
    coord_t offset_y;
    coord_t segment_dx;
    coord_t segment_dy;
    coord_t ray_dx;
    coord_t ray_dy;
  } ray_query_t;

  // One result as the core should return it.
  typedef struct packed {
    logic [QUOT_W-1:0] inverse_distance;
    logic              hit;
  } hit_result_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 100;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  coord_t            offset_x_i;
  coord_t            offset_y_i;
  coord_t            segment_dx_i;
  coord_t            segment_dy_i;
  coord_t            ray_dx_i;
  coord_t            ray_dy_i;
  logic              result_valid_o;
  logic [QUOT_W-1:0] inverse_distance_o;
  logic              hit_o;

  hit_result_t pending_distances[$];
  int          mismatch_count;
  int          cycle_count;

  ray_segment_inverse_distance_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .offset_x_i         (offset_x_i),
    .offset_y_i         (offset_y_i),
    .segment_dx_i       (segment_dx_i),
    .segment_dy_i       (segment_dy_i),
    .ray_dx_i           (ray_dx_i),
    .ray_dy_i           (ray_dy_i),
    .result_valid_o     (result_valid_o),
    .inverse_distance_o (inverse_distance_o),
    .hit_o              (hit_o)
  );

  // Free-running clock with a period of 10.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Exact integer form of the hit test: three cross products, a sign fold so
  // the determinant is positive, the range checks and the floored quotient.
  function automatic hit_result_t predict_inverse_distance(input ray_query_t query);
    longint      ox, oy, sx, sy, rx, ry;
    longint      det, seg_num, ray_num;
    hit_result_t result;
    ox = $signed(query.offset_x);
    oy = $signed(query.offset_y);
    sx = $signed(query.segment_dx);
    sy = $signed(query.segment_dy);
    rx = $signed(query.ray_dx);
    ry = $signed(query.ray_dy);
    det     = rx * sy - ry * sx;
    seg_num = rx * oy - ry * ox;
    ray_num = sx * oy - sy * ox;
    result  = '0;
    if (det != 0) begin
      if (det < 0) begin
        det     = -det;
        seg_num = -seg_num;
        ray_num = -ray_num;
      end
      if (seg_num >= 0 && seg_num <= det && ray_num >= 0) begin
        result.hit              = 1'b1;
        result.inverse_distance = QUOT_W'((det << FRAC_BITS) / (det + ray_num));
      end
    end
    return result;
  endfunction

  function automatic ray_query_t build_query(input int ox, input int oy, input int sx,
                                             input int sy, input int rx, input int ry);
    ray_query_t query;
    query.offset_x   = coord_t'(ox);
    query.offset_y   = coord_t'(oy);
    query.segment_dx = coord_t'(sx);
    query.segment_dy = coord_t'(sy);
    query.ray_dx     = coord_t'(rx);
    query.ray_dy     = coord_t'(ry);
    return query;
  endfunction

  // Uniform integer in [-limit, limit].
  function automatic int rand_span(input int limit);
    return int'($urandom_range(0, 2 * limit)) - limit;
  endfunction

  // A query built around a hit: the origin sits at a point along the segment,
  // backed off along the ray. Integer rounding and a negative back-off give
  // near misses and rays pointing away as well.
  function automatic ray_query_t make_hit_query();
    int span, steps, along, reach, ray_span;
    int sx, sy, rx, ry;
    case ($urandom_range(0, 2))
      0:       span = 255;
      1:       span = 4095;
      default: span = 16383;
    endcase
    steps    = $urandom_range(1, 64);
    along    = $urandom_range(0, steps);
    reach    = int'($urandom_range(0, 10)) - 2;
    ray_span = span / ((reach < 0 ? -reach : reach) + 1);
    sx = rand_span(span);
    sy = rand_span(span);
    rx = rand_span(ray_span);
    ry = rand_span(ray_span);
    return build_query((along * sx) / steps - reach * rx, (along * sy) / steps - reach * ry,
                       sx, sy, rx, ry);
  endfunction

  // Unshaped queries: either every bit random or tiny values that often make
  // degenerate and parallel geometry.
  function automatic ray_query_t make_noise_query();
    if ($urandom_range(0, 2) == 0) begin
      return build_query(rand_span(8), rand_span(8), rand_span(8), rand_span(8),
                         rand_span(8), rand_span(8));
    end
    return build_query($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, 8));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    // Keep the log short when the core is badly broken; every failure still counts.
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // Transfer one query after idle_cycles with start low, and record
  // its expected result once the core takes it.
  task automatic send_query(input ray_query_t query, input int idle_cycles);
    repeat (idle_cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    offset_x_i   <= query.offset_x;
    offset_y_i   <= query.offset_y;
    segment_dx_i <= query.segment_dx;
    segment_dy_i <= query.segment_dy;
    ray_dx_i     <= query.ray_dx;
    ray_dy_i     <= query.ray_dy;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    pending_distances.push_back(predict_inverse_distance(query));
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Each result is compared with the oldest expectation.
  always @(posedge clk_i) begin
    hit_result_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_distances.size() == 0) begin
        report_mismatch("result with nothing outstanding", inverse_distance_o, 0);
      end else begin
        want = pending_distances.pop_front();
        if (hit_o !== want.hit) begin
          report_mismatch("hit_o", hit_o, want.hit);
        end
        if (inverse_distance_o !== want.inverse_distance) begin
          report_mismatch("inverse_distance_o", inverse_distance_o, want.inverse_distance);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hand-picked geometry: endpoints, misses on each side, parallel and
  // degenerate segments, a ray origin on the segment and coordinate extremes.
  task automatic test_directed_geometry();
    send_query(build_query(0, 0, 0, 0, 0, 0), 0);
    send_query(build_query(-5, 5, 0, 10, 1, 0), 0);           // plain hit at r = 5
    send_query(build_query(-5, 0, 0, 10, 1, 0), 0);           // hit on the segment start
    send_query(build_query(-5, 10, 0, 10, 1, 0), 0);          // hit on the segment end
    send_query(build_query(-5, 11, 0, 10, 1, 0), 0);          // just past the end
    send_query(build_query(-5, -1, 0, 10, 1, 0), 0);          // just before the start
    send_query(build_query(0, 5, 0, 10, 1, 0), 0);            // origin on the segment
    send_query(build_query(5, 5, 0, 10, 1, 0), 0);            // segment behind the ray
    send_query(build_query(5, 5, 0, 10, -1, 0), 0);           // negative determinant, hit
    send_query(build_query(-5, 5, 0, 10, 0, 1), 0);           // parallel lines
    send_query(build_query(0, -5, 0, 10, 0, 1), 0);           // collinear overlap
    send_query(build_query(-5, 0, 0, 0, 1, 0), 0);            // zero-length segment
    send_query(build_query(-32768, 0, 0, 32767, 1, 0), 0);    // far hit, tiny result
    send_query(build_query(-32768, 1, 32767, 1, 1, 0), 0);
    send_query(build_query(-32768, -32768, -32768, -32768, -32768, -32768), 0);
    send_query(build_query(32767, 32767, 32767, 32767, 32767, 32767), 0);
    send_query(build_query(0, 0, 32767, -32768, -32768, -32768), 0);
    send_query(build_query(-32768, 32767, 32767, -32768, -32768, -32768), 0);
    send_query(build_query(32767, -32768, -32768, 32767, 32767, -32768), 0);
    send_query(build_query(0, 0, -32768, 0, 0, -32768), 3);
    send_query(build_query(16384, -16384, -32768, 32767, 32767, 32767), 0);
    stop_sending();
  endtask

  // Hit-shaped queries back to back, one transfer per cycle.
  task automatic test_streaming_hits();
    for (int i = 0; i < 300; i++) begin
      send_query(make_hit_query(), 0);
    end
    stop_sending();
  endtask

  // Mostly hit-shaped queries with noise mixed in, and random gaps broken up
  // by stretches without any.
  task automatic test_random_mix();
    bit steady;
    for (int i = 0; i < 1400; i++) begin
      steady = ((i / 50) % 4) == 0;
      if ($urandom_range(0, 9) < 6) begin
        send_query(make_hit_query(), draw_gap(steady));
      end else begin
        send_query(make_noise_query(), draw_gap(steady));
      end
    end
    stop_sending();
  endtask

  // Let the pipeline run empty between two bursts.
  task automatic test_drain_and_resume();
    for (int i = 0; i < 20; i++) begin
      send_query(make_hit_query(), draw_gap(i < 10));
    end
    stop_sending();
    while (pending_distances.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 210; i++) begin
      send_query($urandom_range(0, 3) == 0 ? make_noise_query() : make_hit_query(),
                 draw_gap(i >= 100));
    end
    stop_sending();
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    offset_x_i     = '0;
    offset_y_i     = '0;
    segment_dx_i   = '0;
    segment_dy_i   = '0;
    ray_dx_i       = '0;
    ray_dy_i       = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_geometry();
    test_streaming_hits();
    test_random_mix();
    test_drain_and_resume();

    // Wait for the last results, then a little longer for stray ones.
    while (pending_distances.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
